[rtl/lsss_pkg.sv]
// Package: shared constants, types and helpers for the looped sample sequence store.
`timescale 1ns / 1ps
package lsss_pkg;

    localparam int DEPTH      = 256;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 9;
    localparam int SMP_W      = 16;
    localparam int CNT_W      = 16;
    localparam int CMD_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_CONST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RAMP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    typedef enum logic [1:0] {
        K_FILL,
        K_READ,
        K_QUERY
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [SMP_W-1:0]  value;
        logic [SMP_W-1:0]  step;
        logic [CNT_W-1:0]  count;
    } t_op;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] x);
        logic [31:0] v;
        v = 32'(x);
        if (v == 32'd0) begin
            v = 32'd1;
        end
        if (v > 32'(DEPTH)) begin
            v = 32'(DEPTH);
        end
        return LEN_W'(v);
    endfunction

endpackage

[rtl/lsss_in_if.sv]
// Interface: command request channel.
`timescale 1ns / 1ps
interface lsss_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [15:0]       value;
    logic signed [15:0]       step;
    logic [15:0]              run_length;

    modport source (output valid, command, value, step, run_length, input ready);
    modport sink   (input valid, command, value, step, run_length, output ready);
endinterface

[rtl/lsss_out_if.sv]
// Interface: result request channel.
`timescale 1ns / 1ps
interface lsss_out_if;
    logic                     valid;
    logic                     ready;
    logic signed [15:0]       sample;
    logic                     had_data;
    logic                     end_of_sequence;

    modport source (output valid, sample, had_data, end_of_sequence, input ready);
    modport sink   (input valid, sample, had_data, end_of_sequence, output ready);
endinterface

[rtl/lsss_cfg_if.sv]
// Interface: sequence length configuration write channel.
`timescale 1ns / 1ps
interface lsss_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [8:0]               data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[rtl/lsss_front.sv]
// Front end: accepts command requests and turns them into queue operations.
`timescale 1ns / 1ps
module lsss_front (
    lsss_in_if.sink              i_in,
    output logic                 o_push,
    output lsss_pkg::t_op        o_op,
    input  logic                 i_queue_ready
);
    import lsss_pkg::*;

    logic drop;

    always_comb begin
        o_op.value = SMP_W'(i_in.value);
        o_op.step  = '0;
        o_op.count = i_in.run_length;
        drop       = 1'b0;
        case (i_in.command)
            CMD_CONST: begin
                o_op.kind = K_FILL;
                drop      = (i_in.run_length == '0);
            end
            CMD_RAMP: begin
                o_op.kind = K_FILL;
                o_op.step = SMP_W'(i_in.step);
                drop      = (i_in.run_length == '0);
            end
            CMD_READ: begin
                o_op.kind = K_READ;
            end
            default: begin
                o_op.kind = K_QUERY;
            end
        endcase
    end

    // zero-length adds are accepted and dropped here
    assign i_in.ready = i_queue_ready;
    assign o_push     = i_in.valid && i_queue_ready && !drop;

endmodule

[rtl/lsss_queue.sv]
// Short queue of operations between front end and back end.
`timescale 1ns / 1ps
module lsss_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lsss_pkg::t_op        i_op,
    output logic                 o_ready,
    output logic                 o_valid,
    output lsss_pkg::t_op        o_op,
    input  logic                 i_pop
);
    import lsss_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/lsss_back.sv]
// Back end: sample memory, fill sequencer, playback read and result register.
`timescale 1ns / 1ps
module lsss_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  lsss_pkg::t_op        i_op,
    output logic                 o_pop,
    lsss_cfg_if.sink             i_cfg,
    lsss_out_if.source           o_out
);
    import lsss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_READ
    } t_state;

    t_state             r_state;
    logic [SMP_W-1:0]   r_mem [DEPTH];
    logic [SMP_W-1:0]   r_rd_data;
    logic [LEN_W-1:0]   r_len;
    logic [ADDR_W-1:0]  r_wr_pos;
    logic [ADDR_W-1:0]  r_rd_pos;
    logic [LEN_W-1:0]   r_fill;
    logic               r_flag;
    logic [SMP_W-1:0]   r_fill_val;
    logic [SMP_W-1:0]   r_fill_step;
    logic [CNT_W-1:0]   r_remain;
    logic               r_out_valid;
    logic [SMP_W-1:0]   r_out_sample;
    logic               r_out_had;
    logic               r_out_eos;

    logic [ADDR_W-1:0]  n_wr_pos;
    logic [ADDR_W-1:0]  n_rd_pos;
    logic [LEN_W-1:0]   n_fill;
    logic [LEN_W:0]     wr_inc;
    logic [LEN_W:0]     rd_inc;
    logic [LEN_W:0]     fill_inc;
    logic               out_free;
    logic               have_data;

    assign out_free  = !r_out_valid || o_out.ready;
    assign have_data = (r_fill != '0);
    assign o_pop     = (r_state == S_IDLE) && i_op_valid &&
                       ((i_op.kind == K_FILL) || out_free);

    always_comb begin
        wr_inc   = (LEN_W + 1)'(r_wr_pos) + 1'b1;
        rd_inc   = (LEN_W + 1)'(r_rd_pos) + 1'b1;
        fill_inc = (LEN_W + 1)'(r_fill) + 1'b1;
        n_wr_pos = (wr_inc >= (LEN_W + 1)'(r_len)) ? '0 : ADDR_W'(wr_inc);
        n_rd_pos = (rd_inc >= (LEN_W + 1)'(r_fill)) ? '0 : ADDR_W'(rd_inc);
        n_fill   = (fill_inc > (LEN_W + 1)'(r_len)) ? r_len : LEN_W'(fill_inc);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FILL) begin
            r_mem[r_wr_pos] <= r_fill_val;
        end
        r_rd_data <= r_mem[r_rd_pos];
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= clamp_len(CFG_W'(DEPTH));
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
            r_fill      <= '0;
            r_flag      <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_len <= clamp_len(i_cfg.data);
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_op.kind)
                            K_FILL: begin
                                r_fill_val  <= i_op.value;
                                r_fill_step <= i_op.step;
                                r_remain    <= i_op.count;
                                r_state     <= S_FILL;
                            end
                            K_READ: begin
                                if (have_data) begin
                                    r_rd_pos <= n_rd_pos;
                                    r_flag   <= (n_rd_pos == '0);
                                    r_state  <= S_READ;
                                end else begin
                                    r_out_valid  <= 1'b1;
                                    r_out_sample <= '0;
                                    r_out_had    <= 1'b0;
                                    r_out_eos    <= r_flag;
                                end
                            end
                            default: begin
                                r_out_valid  <= 1'b1;
                                r_out_sample <= '0;
                                r_out_had    <= have_data;
                                r_out_eos    <= r_flag;
                            end
                        endcase
                    end
                end
                S_FILL: begin
                    r_wr_pos   <= n_wr_pos;
                    r_fill     <= n_fill;
                    r_fill_val <= r_fill_val + r_fill_step;
                    r_remain   <= r_remain - 1'b1;
                    if (r_remain == CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_out_valid  <= 1'b1;
                    r_out_sample <= r_rd_data;
                    r_out_had    <= 1'b1;
                    r_out_eos    <= r_flag;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.sample          = signed'(r_out_sample);
    assign o_out.had_data        = r_out_had;
    assign o_out.end_of_sequence = r_out_eos;

endmodule

[rtl/looped_sample_sequence_store_unit.sv]
// Top level: looped sample sequence store, front end, queue and back end.
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+------------
//  i_in     | in        | command, value, step, run_length         | valid/ready
//  o_out    | out       | sample, had_data, end_of_sequence        | valid/ready
//  i_cfg    | in        | data (seq_length, 9 bits)                | valid/ready
//
//  A fill command holds the back end for a dispatch step, then for one memory
//  write per sample.
//  A read of a filled store goes through S_READ for the registered memory read;
//  an empty-store read and a flag query do not. The queue registers requests.
//  The front end and a 2-entry queue take requests while the back end works or
//  the result register waits on o_out.ready.
//  Synchronous active-low reset; no memory clearing pass, sample memory is unset.
`timescale 1ns / 1ps
module looped_sample_sequence_store_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lsss_in_if.sink     i_in,
    lsss_cfg_if.sink    i_cfg,
    lsss_out_if.source  o_out
);
    import lsss_pkg::*;

    logic push;
    t_op  push_op;
    logic queue_ready;
    logic op_valid;
    t_op  op;
    logic pop;

    lsss_front u_front (
        .i_in          (i_in),
        .o_push        (push),
        .o_op          (push_op),
        .i_queue_ready (queue_ready)
    );

    lsss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (queue_ready),
        .o_valid (op_valid),
        .o_op    (op),
        .i_pop   (pop)
    );

    lsss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .o_pop      (pop),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

[tb/lsss_playback_checker.sv]
// Checker: follows the store requests, predicts playback results and compares them.
`timescale 1ns / 1ps
module lsss_playback_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lsss_in_if   i_in,
    lsss_cfg_if  i_cfg,
    lsss_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import lsss_pkg::*;

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             had_data;
        logic             end_flag;
    } t_playback;

    logic [SMP_W-1:0]  slot_mem [DEPTH];
    logic [ADDR_W-1:0] wr_slot;
    logic [ADDR_W-1:0] rd_slot;
    logic [LEN_W-1:0]  filled;
    logic              loop_end;
    logic [CFG_W-1:0]  seq_len;
    t_playback         pending_playback [$];

    function automatic logic [LEN_W-1:0] active_slots(input logic [CFG_W-1:0] n);
        if (n == '0) begin
            return LEN_W'(1);
        end
        if (n > CFG_W'(DEPTH)) begin
            return LEN_W'(DEPTH);
        end
        return LEN_W'(n);
    endfunction

    task automatic report_mismatch(input string what, input logic [SMP_W-1:0] got,
                                   input logic [SMP_W-1:0] want);
        if (o_fail_count < 100) begin
            $display("[%0t] %s mismatch: got 0x%h, expected 0x%h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic store_sample(input logic [SMP_W-1:0] v);
        logic [LEN_W-1:0] slots;
        logic [LEN_W-1:0] next_slot;
        slots = active_slots(seq_len);
        slot_mem[wr_slot] = v;
        next_slot = LEN_W'(wr_slot) + 1'b1;
        wr_slot = (next_slot > slots - 1'b1) ? '0 : next_slot[ADDR_W-1:0];
        filled = (filled >= slots) ? slots : filled + 1'b1;
    endtask

    task automatic play_request(input logic [CMD_W-1:0] cmd, input logic [SMP_W-1:0] val,
                                input logic [SMP_W-1:0] stp, input logic [CNT_W-1:0] cnt);
        t_playback        res;
        logic [SMP_W-1:0] level;
        logic [LEN_W-1:0] next_slot;
        level = val;
        res = '0;
        case (cmd)
            CMD_CONST: begin
                for (int i = 0; i < cnt; i++) begin
                    store_sample(val);
                end
            end
            CMD_RAMP: begin
                for (int i = 0; i < cnt; i++) begin
                    store_sample(level);
                    level = level + stp;
                end
            end
            default: begin
                if (cmd == CMD_READ && filled != '0) begin
                    res.sample = slot_mem[rd_slot];
                    next_slot = LEN_W'(rd_slot) + 1'b1;
                    rd_slot = (next_slot > filled - 1'b1) ? '0 : next_slot[ADDR_W-1:0];
                    loop_end = (rd_slot == '0);
                end
                res.had_data = (filled != '0);
                res.end_flag = loop_end;
                pending_playback.push_back(res);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_playback want;
        if (!i_rst_n) begin
            wr_slot = '0;
            rd_slot = '0;
            filled = '0;
            loop_end = 1'b0;
            seq_len = CFG_W'(DEPTH);
            o_fail_count = 0;
            pending_playback.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (pending_playback.size() == 0) begin
                    report_mismatch("unexpected result", i_out.sample, '0);
                end else begin
                    want = pending_playback.pop_front();
                    if (i_out.sample !== want.sample) begin
                        report_mismatch("sample", i_out.sample, want.sample);
                    end
                    if (i_out.had_data !== want.had_data) begin
                        report_mismatch("had_data", SMP_W'(i_out.had_data), SMP_W'(want.had_data));
                    end
                    if (i_out.end_of_sequence !== want.end_flag) begin
                        report_mismatch("end_of_sequence", SMP_W'(i_out.end_of_sequence),
                                        SMP_W'(want.end_flag));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                seq_len = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                play_request(i_in.command, i_in.value, i_in.step, i_in.run_length);
            end
        end
        o_pending = pending_playback.size();
    end

endmodule

[tb/looped_sample_sequence_store_unit_tb.sv]
// Testbench top: drives store requests and length writes, and gives the verdict.
`timescale 1ns / 1ps
module looped_sample_sequence_store_unit_tb;
    import lsss_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic clk = 1'b0;
    logic rst_n;
    int   send_gap;
    int   recv_stall;
    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    lsss_in_if  in_ch ();
    lsss_cfg_if cfg_ch ();
    lsss_out_if out_ch ();

    looped_sample_sequence_store_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    lsss_playback_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("looped_sample_sequence_store_unit verification failed");
            $finish;
        end
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return 16'h8000;
        end else if (r < 16) begin
            return 16'h7FFF;
        end else if (r < 20) begin
            return 16'hFFFF;
        end else if (r < 24) begin
            return 16'h0000;
        end
        return 16'($urandom);
    endfunction

    // Called just after a falling edge; returns at the falling edge after the request.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SMP_W-1:0] val,
                                input logic [SMP_W-1:0] stp, input logic [CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < send_gap) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.value      <= val;
        in_ch.step       <= stp;
        in_ch.run_length <= cnt;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_probe(input logic [CMD_W-1:0] cmd);
        send_request(cmd, pick_sample(), pick_sample(), 16'($urandom));
    endtask

    task automatic settle_results();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // A flag query flushes pending fills ahead of the length write.
    task automatic write_length(input logic [CFG_W-1:0] len);
        send_probe(CMD_QUERY);
        settle_results();
        repeat (4) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_request();
        logic [CMD_W-1:0] cmd;
        logic [CNT_W-1:0] cnt;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            cmd = CMD_READ;
        end else if (r < 55) begin
            cmd = CMD_QUERY;
        end else if (r < 78) begin
            cmd = CMD_CONST;
        end else begin
            cmd = CMD_RAMP;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            cnt = '0;
        end else if (r < 80) begin
            cnt = CNT_W'($urandom_range(1, 8));
        end else if (r < 96) begin
            cnt = CNT_W'($urandom_range(9, 40));
        end else begin
            cnt = CNT_W'($urandom_range(200, 300));
        end
        send_request(cmd, pick_sample(), pick_sample(), cnt);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] len, input int gap, input int stall,
                             input int items, input bit hold_off);
        send_gap = gap;
        recv_stall = stall;
        write_length(len);
        for (int n = 0; n < items; n++) begin
            if (hold_off && n == items / 2) begin
                settle_results();
            end
            random_request();
        end
    endtask

    initial begin
        rst_n = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_CONST;
        in_ch.value = '0;
        in_ch.step = '0;
        in_ch.run_length = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store, zero-length adds, then a full ramp so every slot holds data
        write_length(9'd256);
        send_probe(CMD_READ);
        send_request(CMD_CONST, 16'h7FFF, 16'h0000, 16'd0);
        send_request(CMD_RAMP, 16'h8000, 16'h7FFF, 16'd0);
        send_probe(CMD_READ);
        send_request(CMD_RAMP, 16'h8000, 16'h0001, 16'd256);
        repeat (2) send_probe(CMD_READ);
        send_probe(CMD_QUERY);
        send_request(CMD_CONST, 16'h7FFF, 16'hFFFF, 16'd3);
        send_request(CMD_RAMP, 16'h7FFF, 16'h7FFF, 16'd4);
        send_request(CMD_RAMP, 16'h0000, 16'hFFFF, 16'd5);
        send_request(CMD_RAMP, 16'h1234, 16'h8000, 16'd2);
        repeat (3) send_probe(CMD_READ);
        send_request(CMD_CONST, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_probe(CMD_READ);
        send_probe(CMD_QUERY);
        // zero length acts as one; read position left beyond the new length
        write_length(9'd0);
        repeat (2) send_probe(CMD_READ);
        send_request(CMD_CONST, 16'h5A5A, 16'h0000, 16'd2);
        send_probe(CMD_READ);
        send_probe(CMD_QUERY);

        run_phase(9'd256, 0, 0, 150, 1'b0);
        run_phase(9'd1, 85, 0, 100, 1'b0);
        run_phase(9'd0, 0, 85, 100, 1'b0);
        run_phase(9'd7, 20, 20, 100, 1'b0);
        run_phase(9'd511, 0, 0, 120, 1'b0);
        run_phase(CFG_W'($urandom_range(2, 64)), 85, 0, 100, 1'b1);
        run_phase(9'd300, 0, 85, 80, 1'b0);
        run_phase(9'd256, 20, 20, 100, 1'b1);

        settle_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0) begin
            $display("looped_sample_sequence_store_unit verification clean");
        end else begin
            $display("looped_sample_sequence_store_unit verification failed");
        end
        $finish;
    end

endmodule
